/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check
`define EPWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a check in the next
`define EPWR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/epwr_pkg.sv */
// ----------------------------------------------------------------------------
// epwr_pkg
// types and constants shared by the echo pulse width ranger
// ----------------------------------------------------------------------------
package epwr_pkg;

  localparam int CHANNELS_DEF   = 6;
  localparam int TIMER_BITS_DEF = 16;
  localparam int ENABLE_BITS    = 6;
  localparam int CH_W           = 3;
  localparam int CAP_W          = 16;
  localparam int PERIOD_W       = 16;
  localparam int DIST_W         = 22;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam int unsigned MM100_PER_TICK = 17;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = {PERIOD_W{1'b1}};

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_READ    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_START    = 2'd0,
    ST_DONE     = 2'd1,
    ST_READ     = 2'd2,
    ST_DISABLED = 2'd3
  } status_t;

  typedef enum logic {
    REG_TIMER_PERIOD = 1'b0,
    REG_ENABLE_MASK  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  channel;
    logic [CAP_W-1:0] capture_value;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    status_t           status;
    logic [DIST_W-1:0] distance;
  } result_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]    timer_period;
    logic [ENABLE_BITS-1:0] enable_mask;
  } cfg_t;

endpackage

/* rtl/epwr_cfg.sv */
// ----------------------------------------------------------------------------
// epwr_cfg
// apb register block: timer period and channel enable mask
// ----------------------------------------------------------------------------
module epwr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [epwr_pkg::ADDR_W-1:0]   paddr,
  input  logic [epwr_pkg::DATA_W-1:0]   pwdata,
  output logic [epwr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output epwr_pkg::cfg_t                cfg
);
  import epwr_pkg::*;
  `include "assert_macros.svh"

  logic [PERIOD_W-1:0]    period_r;
  logic [ENABLE_BITS-1:0] mask_r;
  logic                   wr_en;
  reg_idx_t               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      mask_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TIMER_PERIOD: period_r <= pwdata[PERIOD_W-1:0];
        REG_ENABLE_MASK:  mask_r   <= pwdata[ENABLE_BITS-1:0];
        default:          period_r <= period_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIMER_PERIOD: prdata = DATA_W'(period_r);
      REG_ENABLE_MASK:  prdata = DATA_W'(mask_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.timer_period = period_r;
  assign cfg.enable_mask  = mask_r;

  `EPWR_ASSERT_NEXT(a_period_wr, wr_en && reg_idx == REG_TIMER_PERIOD,
    period_r == $past(pwdata[PERIOD_W-1:0]), "timer period write lost")

endmodule

/* rtl/epwr_core.sv */
// ----------------------------------------------------------------------------
// epwr_core
// per-channel edge state and the width to distance datapath
// ----------------------------------------------------------------------------
module epwr_core #(
  parameter int CHANNELS   = epwr_pkg::CHANNELS_DEF,
  parameter int TIMER_BITS = epwr_pkg::TIMER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  epwr_pkg::cfg_t   cfg,
  input  logic             fire,
  input  epwr_pkg::item_t  item,
  output epwr_pkg::result_t res
);
  import epwr_pkg::*;
  `include "assert_macros.svh"

  localparam int NCH   = (CHANNELS < ENABLE_BITS) ? CHANNELS : ENABLE_BITS;
  localparam int IW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int NSLOT = 1 << IW;
  localparam int TW    = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
  localparam int PW    = ((TW + 6) > (DIST_W + 1)) ? (TW + 6) : (DIST_W + 1);

  logic              phase_r [NSLOT];
  logic [TW-1:0]     start_r [NSLOT];
  logic [DIST_W-1:0] dist_r  [NSLOT];

  logic              en;
  logic [IW-1:0]     idx;
  logic [TW-1:0]     cap_v;
  logic [TW-1:0]     start_v;
  logic [TW-1:0]     per_v;
  logic [TW:0]       sum_v;
  logic [TW:0]       width_v;
  logic [PW-1:0]     prod_v;
  logic [DIST_W-1:0] new_dist;

  always_comb begin
    en = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      if (item.channel == CH_W'(i)) en = cfg.enable_mask[i];
    end
  end

  assign idx     = item.channel[IW-1:0];
  assign cap_v   = item.capture_value[TW-1:0];
  assign start_v = start_r[idx];
  assign per_v   = cfg.timer_period[TW-1:0];
  assign sum_v   = {1'b0, per_v} + {1'b0, cap_v};

  always_comb begin
    if (cap_v >= start_v) begin
      width_v = {1'b0, cap_v} - {1'b0, start_v};
    end else if (sum_v >= {1'b0, start_v}) begin
      width_v = sum_v - {1'b0, start_v};
    end else begin
      width_v = '0;
    end
  end

  assign prod_v   = PW'(width_v) * PW'(MM100_PER_TICK);
  assign new_dist = (prod_v > PW'(DIST_MAX)) ? DIST_MAX : prod_v[DIST_W-1:0];

  always_comb begin
    res.channel = item.channel;
    priority if (!en) begin
      res.status   = ST_DISABLED;
      res.distance = '0;
    end else if (item.op == OP_READ) begin
      res.status   = ST_READ;
      res.distance = dist_r[idx];
    end else if (!phase_r[idx]) begin
      res.status   = ST_START;
      res.distance = dist_r[idx];
    end else begin
      res.status   = ST_DONE;
      res.distance = new_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        phase_r[i] <= 1'b0;
        dist_r[i]  <= '0;
      end
    end else if (fire && en && item.op == OP_CAPTURE) begin
      phase_r[idx] <= !phase_r[idx];
      if (phase_r[idx]) dist_r[idx] <= new_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && en && item.op == OP_CAPTURE && !phase_r[idx]) begin
      start_r[idx] <= cap_v;
    end
  end

  `EPWR_ASSERT(a_disabled_zero, !(fire && res.status == ST_DISABLED) || res.distance == '0,
    "disabled channel returned a distance")
  `EPWR_ASSERT_NEXT(a_done_stored, fire && res.status == ST_DONE,
    dist_r[$past(idx)] == $past(res.distance) && !phase_r[$past(idx)],
    "completed measurement not stored")

endmodule

/* rtl/echo_pulse_width_ranger.sv */
// ----------------------------------------------------------------------------
// echo_pulse_width_ranger
// six-channel ultrasonic echo timer: start edge, end edge, distance, read
// an accepted input word is registered in s1_item_r, its result word in out_r
// throughput: one word per cycle while out_stall allows, set by the single-pass state update
// in_stall follows out_stall only while both pipeline registers are full
// reset: synchronous rst_n clears phases, distances, enables, period 65535
// ----------------------------------------------------------------------------
module echo_pulse_width_ranger #(
  parameter int CHANNELS   = epwr_pkg::CHANNELS_DEF,
  parameter int TIMER_BITS = epwr_pkg::TIMER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [epwr_pkg::CH_W-1:0]    in_channel,
  input  logic [epwr_pkg::CAP_W-1:0]   in_capture_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [epwr_pkg::CH_W-1:0]    out_channel,
  output logic [1:0]                   out_status,
  output logic [epwr_pkg::DIST_W-1:0]  out_distance,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [epwr_pkg::ADDR_W-1:0]  paddr,
  input  logic [epwr_pkg::DATA_W-1:0]  pwdata,
  output logic [epwr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import epwr_pkg::*;
  `include "assert_macros.svh"

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    advance;
  logic    in_fire;
  logic    s1_fire;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && advance;

  epwr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  epwr_core #(
    .CHANNELS   (CHANNELS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (s1_fire),
    .item  (s1_item_r),
    .res   (res)
  );

  always_comb begin
    if (advance) s1_valid_nxt = in_fire;
    else         s1_valid_nxt = s1_valid_r || in_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (advance) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.op            <= op_t'(in_op);
      s1_item_r.channel       <= in_channel;
      s1_item_r.capture_value <= in_capture_value;
    end
    if (s1_fire) out_r <= res;
  end

  assign out_valid    = out_valid_r;
  assign out_channel  = out_r.channel;
  assign out_status   = out_r.status;
  assign out_distance = out_r.distance;

  `EPWR_ASSERT_NEXT(a_s1_hold, s1_valid_r && !advance,
    s1_valid_r && $stable(s1_item_r), "held word left the input register")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the echo pulse width ranger: directed edge pairs,
// wrap and clamp cases, disabled and out-of-range channels, then random words
// over several period and enable settings, checked against a local predictor
// ----------------------------------------------------------------------------
module tb_top;
  import epwr_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = 1'b0;
  logic [CH_W-1:0]     in_channel = '0;
  logic [CAP_W-1:0]    in_capture_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CH_W-1:0]     out_channel;
  logic [1:0]          out_status;
  logic [DIST_W-1:0]   out_distance;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  echo_pulse_width_ranger DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_channel(in_channel), .in_capture_value(in_capture_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
    .out_status(out_status), .out_distance(out_distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor copy of the ranger state
  logic [PERIOD_W-1:0]    period_reg = PERIOD_RESET;
  logic [ENABLE_BITS-1:0] enable_reg = '0;
  bit                     ch_armed [CHANNELS_DEF];
  logic [CAP_W-1:0]       ch_start [CHANNELS_DEF];
  logic [DIST_W-1:0]      ch_dist  [CHANNELS_DEF];

  item_t   word_queue [$];
  result_t want_results [$];
  item_t   cur_word;
  int      n_queued = 0;
  int      n_accepted = 0;
  int      errors = 0;
  bit      calm = 1'b0;

  initial begin
    foreach (ch_armed[i]) begin
      ch_armed[i] = 1'b0;
      ch_start[i] = '0;
      ch_dist[i]  = '0;
    end
  end

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 38);
  endfunction

  function automatic result_t range_result(item_t w);
    result_t     r;
    logic [16:0] sum;
    logic [16:0] width;
    logic [31:0] prod;
    r.channel  = w.channel;
    r.distance = '0;
    if (w.channel >= CHANNELS_DEF || !enable_reg[w.channel]) begin
      r.status = ST_DISABLED;
      return r;
    end
    if (w.op == OP_READ) begin
      r.status = ST_READ;
    end else if (!ch_armed[w.channel]) begin
      ch_start[w.channel] = w.capture_value;
      ch_armed[w.channel] = 1'b1;
      r.status = ST_START;
    end else begin
      if (w.capture_value >= ch_start[w.channel]) begin
        width = w.capture_value - ch_start[w.channel];
      end else begin
        sum   = {1'b0, period_reg} + w.capture_value;
        width = (sum >= ch_start[w.channel]) ? sum - ch_start[w.channel] : '0;
      end
      prod = width * MM100_PER_TICK;
      ch_dist[w.channel]  = (prod > DIST_MAX) ? DIST_MAX : prod[DIST_W-1:0];
      ch_armed[w.channel] = 1'b0;
      r.status = ST_DONE;
    end
    r.distance = ch_dist[w.channel];
    return r;
  endfunction

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want_results.push_back(range_result(cur_word));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (word_queue.size() > 0 && !take_gap()) begin
          cur_word = word_queue.pop_front();
          in_valid         <= 1'b1;
          in_op            <= cur_word.op;
          in_channel       <= cur_word.channel;
          in_capture_value <= cur_word.capture_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= take_gap();
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected word ch=%0d status=%0d dist=%0d", $time,
                   out_channel, out_status, out_distance);
        end else begin
          exp_r = want_results.pop_front();
          if (out_channel !== exp_r.channel) begin
            errors++;
            $display("%0t: channel expected %0d actual %0d", $time,
                     exp_r.channel, out_channel);
          end
          if (out_status !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, out_status);
          end
          if (out_distance !== exp_r.distance) begin
            errors++;
            $display("%0t: distance expected %0d actual %0d", $time,
                     exp_r.distance, out_distance);
          end
        end
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TIMER_PERIOD: period_reg = value[PERIOD_W-1:0];
      REG_ENABLE_MASK:  enable_reg = value[ENABLE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic send(op_t op, int ch, int cap);
    item_t w;
    w.op            = op;
    w.channel       = ch[CH_W-1:0];
    w.capture_value = cap[CAP_W-1:0];
    word_queue.push_back(w);
    n_queued++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || want_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int r;
    int ch;
    int cap;
    int n_items;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full period, all channels on
    cfg_write(REG_TIMER_PERIOD, 32'd65535);
    cfg_write(REG_ENABLE_MASK, 32'h3f);
    send(OP_READ, 0, 0);
    send(OP_CAPTURE, 0, 0);
    send(OP_CAPTURE, 0, 65535);
    send(OP_CAPTURE, 1, 65000);
    send(OP_CAPTURE, 1, 100);
    send(OP_CAPTURE, 2, 1234);
    send(OP_CAPTURE, 2, 1234);
    send(OP_READ, 1, 65535);
    send(OP_CAPTURE, 6, 777);
    send(OP_READ, 7, 0);
    send(OP_CAPTURE, 5, 16'haaaa);
    send(OP_CAPTURE, 5, 16'h5555);
    send(OP_READ, 5, 0);
    drain();

    // short period, some channels off, clamped wrap
    cfg_write(REG_TIMER_PERIOD, 32'd100);
    cfg_write(REG_ENABLE_MASK, 32'h15);
    send(OP_CAPTURE, 1, 5);
    send(OP_READ, 1, 0);
    send(OP_CAPTURE, 2, 60000);
    send(OP_CAPTURE, 2, 10);
    send(OP_CAPTURE, 4, 50);
    send(OP_CAPTURE, 4, 20);
    send(OP_CAPTURE, 4, 300);
    drain();

    // channel state kept while disabled
    cfg_write(REG_ENABLE_MASK, 32'h00);
    send(OP_CAPTURE, 4, 500);
    send(OP_READ, 0, 0);
    drain();
    cfg_write(REG_TIMER_PERIOD, 32'd0);
    cfg_write(REG_ENABLE_MASK, 32'h3f);
    send(OP_CAPTURE, 4, 500);
    send(OP_CAPTURE, 3, 500);
    send(OP_CAPTURE, 3, 100);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_TIMER_PERIOD, 32'd65535);
          cfg_write(REG_ENABLE_MASK, 32'h3f);
        end
        1: begin
          cfg_write(REG_TIMER_PERIOD, 32'd0);
          cfg_write(REG_ENABLE_MASK, 32'h3f);
        end
        2: begin
          cfg_write(REG_TIMER_PERIOD, $urandom_range(65535));
          cfg_write(REG_ENABLE_MASK, $urandom_range(63));
        end
        3: begin
          cfg_write(REG_TIMER_PERIOD, $urandom_range(1000));
          cfg_write(REG_ENABLE_MASK, $urandom_range(63));
        end
        4: begin
          cfg_write(REG_TIMER_PERIOD, 32'd65535);
          cfg_write(REG_ENABLE_MASK, 32'h00);
        end
        default: begin
          cfg_write(REG_TIMER_PERIOD, $urandom_range(65535));
          cfg_write(REG_ENABLE_MASK, 32'h3f);
        end
      endcase
      calm = (ph == 5);
      n_items = (ph == 4) ? 20 : 135;
      for (int i = 0; i < n_items; i++) begin
        r   = $urandom_range(99);
        cap = $urandom_range(65535);
        if ($urandom_range(9) == 0) cap = $urandom_range(1) ? 65535 : 0;
        if (r < 10) begin
          ch = $urandom_range(7, 6);
          send($urandom_range(1) ? OP_READ : OP_CAPTURE, ch, cap);
        end else if (r < 25) begin
          send(OP_READ, $urandom_range(5), cap);
        end else begin
          send(OP_CAPTURE, $urandom_range(5), cap);
        end
      end
      drain();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/epwr_pkg.sv
rtl/epwr_cfg.sv
rtl/epwr_core.sv
rtl/echo_pulse_width_ranger.sv
tb/tb_top.sv
